[hw/rtl/assert_macros.svh]
// Assertion helpers used by the classifier core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Flags a condition that must never be true while out of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// Flags a consequent that does not hold in the cycle of its antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[hw/rtl/lcc_pkg.sv]
package lcc_pkg;

    // Default saturation point of the digit counter.
    localparam int MAX_COUNT_DEF = 31;

    // Width of the input word: one digit, padded to a byte.
    localparam int DIGIT_W   = 4;
    localparam int S_TDATA_W = 8;

    // Card network codes.
    localparam logic [1:0] KIND_INVALID = 2'd0;
    localparam logic [1:0] KIND_PFX4    = 2'd1;
    localparam logic [1:0] KIND_PFX5X   = 2'd2;
    localparam logic [1:0] KIND_PFX3X   = 2'd3;

    // Card lengths that the networks use.
    localparam int LEN_SHORT = 13;
    localparam int LEN_MID   = 15;
    localparam int LEN_LONG  = 16;

    typedef logic [DIGIT_W-1:0] digit_t;

    // Verdict handed from the digit unit to the result register.
    typedef struct packed {
        logic [1:0] kind;
        logic       ok;
    } lcc_verdict_t;

    // Folds a raw 4-bit code onto 0..9.
    function automatic digit_t lcc_mod10(input digit_t raw);
        return (raw >= digit_t'(10)) ? digit_t'(raw - digit_t'(10)) : raw;
    endfunction

    // Luhn doubling: 2d, minus 9 when that reaches ten.
    function automatic digit_t lcc_double(input digit_t d);
        digit_t r;
        case (d)
            4'd0:    r = 4'd0;
            4'd1:    r = 4'd2;
            4'd2:    r = 4'd4;
            4'd3:    r = 4'd6;
            4'd4:    r = 4'd8;
            4'd5:    r = 4'd1;
            4'd6:    r = 4'd3;
            4'd7:    r = 4'd5;
            4'd8:    r = 4'd7;
            4'd9:    r = 4'd9;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    // Adds two values in 0..9 modulo ten.
    function automatic digit_t lcc_add_mod10(input digit_t a, input digit_t b);
        logic [DIGIT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= 5'd10) ? digit_t'(s - 5'd10) : digit_t'(s);
    endfunction

endpackage

[hw/rtl/lcc_digit_unit.sv]
module lcc_digit_unit #(
    parameter int MAX_COUNT = lcc_pkg::MAX_COUNT_DEF,
    localparam int CountW   = $clog2(MAX_COUNT + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  lcc_pkg::digit_t      digit,
    input  logic                 is_last,
    output lcc_pkg::lcc_verdict_t verdict,
    output logic [CountW-1:0]    len
);
    import lcc_pkg::*;

    digit_t            sum_even_reg, sum_even_next;
    digit_t            sum_odd_reg,  sum_odd_next;
    logic [CountW-1:0] count_reg,    count_next;
    digit_t            first_reg,    first_next;
    digit_t            second_reg,   second_next;

    digit_t d;
    digit_t dbl;
    digit_t sum_pick;
    logic   len_short, len_mid, len_long;

    // Digit update: both parity sums, the count and the prefix.
    always_comb begin
        d             = lcc_mod10(digit);
        dbl           = lcc_double(d);
        first_next    = (count_reg == '0) ? d : first_reg;
        second_next   = (count_reg == CountW'(1)) ? d : second_reg;
        if (!count_reg[0]) begin
            sum_even_next = lcc_add_mod10(sum_even_reg, dbl);
            sum_odd_next  = lcc_add_mod10(sum_odd_reg, d);
        end else begin
            sum_even_next = lcc_add_mod10(sum_even_reg, d);
            sum_odd_next  = lcc_add_mod10(sum_odd_reg, dbl);
        end
        count_next = (count_reg < CountW'(MAX_COUNT)) ? count_reg + CountW'(1) : count_reg;
    end

    // Verdict for a number that ends with this digit.
    always_comb begin
        len         = count_next;
        sum_pick    = len[0] ? sum_odd_next : sum_even_next;
        verdict.ok  = (sum_pick == '0);
        len_short   = (len == CountW'(LEN_SHORT));
        len_mid     = (len == CountW'(LEN_MID));
        len_long    = (len == CountW'(LEN_LONG));
        verdict.kind = KIND_INVALID;
        if (verdict.ok) begin
            if (first_next == 4'd4 && (len_short || len_long)) begin
                verdict.kind = KIND_PFX4;
            end else if (first_next == 4'd5 && second_next >= 4'd1 && second_next <= 4'd5
                         && len_long) begin
                verdict.kind = KIND_PFX5X;
            end else if (first_next == 4'd3 && (second_next == 4'd4 || second_next == 4'd7)
                         && len_mid) begin
                verdict.kind = KIND_PFX3X;
            end
        end
    end

    // Running state; a final digit clears it for the next number.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_even_reg <= '0;
            sum_odd_reg  <= '0;
            count_reg    <= '0;
            first_reg    <= '0;
            second_reg   <= '0;
        end else if (step) begin
            if (is_last) begin
                sum_even_reg <= '0;
                sum_odd_reg  <= '0;
                count_reg    <= '0;
                first_reg    <= '0;
                second_reg   <= '0;
            end else begin
                sum_even_reg <= sum_even_next;
                sum_odd_reg  <= sum_odd_next;
                count_reg    <= count_next;
                first_reg    <= first_next;
                second_reg   <= second_next;
            end
        end
    end

endmodule

[hw/rtl/luhn_card_number_classifier_core.sv]
// Luhn card number classifier.
// The slave channel takes one decimal digit per word, most significant
// first, in s_tdata[3:0]; s_tlast marks the final digit of a number.
// Codes 10 to 15 are folded onto 0 to 5.
// The master channel carries one word per number, sent for its final
// digit: card kind, Luhn check flag and the digit count, which saturates
// at MAX_COUNT.
// A digit word enters an input register; from there the Luhn sums,
// counter and prefix are updated and, for a final digit, the verdict is
// computed in one pass into the result register, whose word shows on the
// master side.
// Throughput is one digit per cycle except while a final digit stalls. Only
// a final digit needs the result register, so when the receiver holds
// m_tready low with a word pending, a final digit waits in the input
// register and s_tready drops; other digits keep flowing.
// Reset clears the sums, the counter, the prefix and both valid flags.
`include "assert_macros.svh"

module luhn_card_number_classifier_core #(
    parameter int MAX_COUNT = lcc_pkg::MAX_COUNT_DEF,
    localparam int CountW   = $clog2(MAX_COUNT + 1),
    localparam int MDataW   = ((3 + CountW + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lcc_pkg::S_TDATA_W-1:0] s_tdata,   // [3:0] digit, rest zero
    input  logic                          s_tlast,   // is_last
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [MDataW-1:0]             m_tdata    // card_kind, checksum_ok, digit_count
);
    import lcc_pkg::*;

    logic              in_vld_reg, in_vld_next;
    digit_t            in_digit_reg;
    logic              in_last_reg;
    logic              out_vld_reg, out_vld_next;
    lcc_verdict_t      out_verdict_reg;
    logic [CountW-1:0] out_count_reg;

    logic              advance;
    logic              s_take;
    lcc_verdict_t      verdict;
    logic [CountW-1:0] len;

    // A digit moves on unless it is final and the result register is full and not being read.
    assign advance  = in_vld_reg && (!in_last_reg || !out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    lcc_digit_unit #(
        .MAX_COUNT(MAX_COUNT)
    ) u_digit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .digit   (in_digit_reg),
        .is_last (in_last_reg),
        .verdict (verdict),
        .len     (len)
    );

    // Valid flags of both registers.
    always_comb begin
        in_vld_next = s_take ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
        if (advance && in_last_reg) begin
            out_vld_next = 1'b1;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end else begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Input word and result word payloads.
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_digit_reg <= s_tdata[DIGIT_W-1:0];
            in_last_reg  <= s_tlast;
        end
        if (advance && in_last_reg) begin
            out_verdict_reg <= verdict;
            out_count_reg   <= len;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(MDataW - 3 - CountW){1'b0}}, out_count_reg,
                       out_verdict_reg.ok, out_verdict_reg.kind};

    `ASSERT_NEVER(a_count_sat, aclk, aresetn,
        m_tvalid && (out_count_reg > CountW'(MAX_COUNT)), "digit count above saturation")
    `ASSERT_IMPLIES(a_kind_needs_ok, aclk, aresetn,
        m_tvalid && (out_verdict_reg.kind != KIND_INVALID), out_verdict_reg.ok,
        "network reported without a passing checksum")
    `ASSERT_IMPLIES(a_pfx5_len, aclk, aresetn,
        m_tvalid && (out_verdict_reg.kind == KIND_PFX5X),
        out_count_reg == CountW'(LEN_LONG), "prefix 51..55 network with wrong length")
    `ASSERT_IMPLIES(a_inner_no_stall, aclk, aresetn,
        in_vld_reg && !in_last_reg, advance, "non-final digit stalled")

endmodule
